// File: design/mxyr_pkg.sv
// shared widths and register addresses for the mesh xy route generator
package mxyr_pkg;

	localparam int NODE_W = 8;
	localparam int REG_W  = 5;
	localparam int ADDR_W = 3;

	localparam logic [ADDR_W-1:0] ADDR_MESH_WIDTH  = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_MESH_HEIGHT = 3'd4;

	localparam logic [REG_W-1:0] RESET_SIDE = 5'd8;

endpackage

// File: design/mxyr_div.sv
// iterative restoring divider, one quotient bit per cycle
module mxyr_div #(
	parameter int SW = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mxyr_pkg::NODE_W-1:0] dividend,
	input  logic [SW-1:0]               divisor,
	output logic [mxyr_pkg::NODE_W-1:0] quotient,
	output logic [SW-1:0]               remainder,
	output logic                        done
);
	import mxyr_pkg::*;

	localparam int CNT_W = $clog2(NODE_W);

	logic [NODE_W-1:0] quo_q;
	logic [SW-1:0]     rem_q;
	logic [SW-1:0]     dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SW:0] trial;
	logic        fits;
	logic [SW:0] diff;

	// the single shared subtract and compare
	assign trial = {rem_q, quo_q[NODE_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NODE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			quo_q <= {quo_q[NODE_W-2:0], fits};
			rem_q <= fits ? diff[SW-1:0] : trial[SW-1:0];
		end else if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// File: design/mesh_xy_route_path_generator.sv
// top level: xy dimension-order route generator with apb registers and stream ports
// sequence: accept, a range check state, then two divisions of 8 quotient bits each (source
// then destination, same divider), then a walk of one hop beat per cycle while the output
// is not stalled; a new item is accepted only in idle, after the last beat of the previous
// item has been loaded, and an out-of-mesh item yields one flagged beat
// reset: arst_n clears control and output valid, width and height return to 8
module mesh_xy_route_path_generator #(
	parameter int MAX_SIDE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// apb configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mxyr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // source_node [7:0], dest_node [15:8]
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // hop_node [7:0]
	output logic                        m_tlast,
	output logic                        m_tuser   // bad_node [0]
);
	import mxyr_pkg::*;

	// clamped side width and coordinate width
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int CMP_W = (2 * SW > NODE_W) ? 2 * SW : NODE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_SRC,
		ST_DIV_DST,
		ST_WALK,
		ST_BAD
	} state_t;

	state_t state_q;

	// configuration registers keep the written bits, clamp is applied on use
	logic [REG_W-1:0] mesh_width_q;
	logic [REG_W-1:0] mesh_height_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_width_q  <= RESET_SIDE;
			mesh_height_q <= RESET_SIDE;
		end else if (cfg_wr) begin
			if (paddr == ADDR_MESH_WIDTH) begin
				mesh_width_q <= pwdata[REG_W-1:0];
			end
			if (paddr == ADDR_MESH_HEIGHT) begin
				mesh_height_q <= pwdata[REG_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr)
			ADDR_MESH_WIDTH:  prdata = 32'(mesh_width_q);
			ADDR_MESH_HEIGHT: prdata = 32'(mesh_height_q);
			default:          prdata = '0;
		endcase
	end

	// zero reads as one, anything above the largest side saturates
	logic [SW-1:0] side_w;
	logic [SW-1:0] side_h;

	always_comb begin
		if (mesh_width_q == '0) begin
			side_w = SW'(1);
		end else if (mesh_width_q > REG_W'(MAX_SIDE)) begin
			side_w = SW'(MAX_SIDE);
		end else begin
			side_w = SW'(mesh_width_q);
		end
		if (mesh_height_q == '0) begin
			side_h = SW'(1);
		end else if (mesh_height_q > REG_W'(MAX_SIDE)) begin
			side_h = SW'(MAX_SIDE);
		end else begin
			side_h = SW'(mesh_height_q);
		end
	end

	// node count of the mesh, a small multiply used only in the check state
	logic [2*SW-1:0] node_total;
	assign node_total = side_w * side_h;

	// captured item
	logic [NODE_W-1:0] src_q;
	logic [NODE_W-1:0] dst_q;

	// walk state
	logic [NODE_W-1:0] cur_node_q;
	logic [CW-1:0]     cur_x_q;
	logic [CW-1:0]     cur_y_q;
	logic [CW-1:0]     tgt_x_q;
	logic [CW-1:0]     tgt_y_q;

	// output beat register
	logic              m_tvalid_q;
	logic [NODE_W-1:0] m_tdata_q;
	logic              m_tlast_q;
	logic              m_tuser_q;

	// shared divider: source first, destination second
	logic              div_start;
	logic [NODE_W-1:0] div_dividend;
	logic [NODE_W-1:0] div_quo;
	logic [SW-1:0]     div_rem;
	logic              div_done;

	mxyr_div #(
		.SW (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (side_w),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	logic out_free;
	logic beat_load;
	logic in_mesh;
	logic at_target;

	assign out_free  = !m_tvalid_q || m_tready;
	// a new beat enters the output register this cycle
	assign beat_load = ((state_q == ST_WALK) || (state_q == ST_BAD)) && out_free;
	assign in_mesh   = (CMP_W'(src_q) < CMP_W'(node_total)) &&
	                   (CMP_W'(dst_q) < CMP_W'(node_total));
	assign at_target = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

	// kick the divider from the check state and again once the source is split
	assign div_start    = ((state_q == ST_CHECK) && in_mesh) ||
	                      ((state_q == ST_DIV_SRC) && div_done);
	assign div_dividend = (state_q == ST_CHECK) ? src_q : dst_q;

	assign s_tready = (state_q == ST_IDLE);

	// sequencer and output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (beat_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= in_mesh ? ST_DIV_SRC : ST_BAD;
				end
				ST_DIV_SRC: begin
					if (div_done) begin
						state_q <= ST_DIV_DST;
					end
				end
				ST_DIV_DST: begin
					if (div_done) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (out_free && at_target) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			src_q <= s_tdata[7:0];
			dst_q <= s_tdata[15:8];
		end

		if ((state_q == ST_DIV_SRC) && div_done) begin
			cur_node_q <= src_q;
			cur_x_q    <= CW'(div_rem);
			cur_y_q    <= CW'(div_quo);
		end

		if ((state_q == ST_DIV_DST) && div_done) begin
			tgt_x_q <= CW'(div_rem);
			tgt_y_q <= CW'(div_quo);
		end

		if ((state_q == ST_WALK) && out_free) begin
			m_tdata_q <= cur_node_q;
			m_tlast_q <= at_target;
			m_tuser_q <= 1'b0;
			// x first, then y
			if (cur_x_q != tgt_x_q) begin
				if (cur_x_q < tgt_x_q) begin
					cur_x_q    <= cur_x_q + 1'b1;
					cur_node_q <= cur_node_q + 1'b1;
				end else begin
					cur_x_q    <= cur_x_q - 1'b1;
					cur_node_q <= cur_node_q - 1'b1;
				end
			end else if (cur_y_q != tgt_y_q) begin
				if (cur_y_q < tgt_y_q) begin
					cur_y_q    <= cur_y_q + 1'b1;
					cur_node_q <= cur_node_q + NODE_W'(side_w);
				end else begin
					cur_y_q    <= cur_y_q - 1'b1;
					cur_node_q <= cur_node_q - NODE_W'(side_w);
				end
			end
		end

		// node outside the mesh: one flagged beat carrying the source
		if ((state_q == ST_BAD) && out_free) begin
			m_tdata_q <= src_q;
			m_tlast_q <= 1'b1;
			m_tuser_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule
